// ===== design/m3alu_pkg.sv =====
// m3alu_pkg: types and constants shared by the 3x3 integer matrix unit
// no dependencies

package m3alu_pkg;

  localparam int MATRIX_SIZE = 3;
  localparam int CELLS       = MATRIX_SIZE * MATRIX_SIZE;
  localparam int CELL_W      = $clog2(CELLS);
  localparam int IDX_W       = $clog2(MATRIX_SIZE);
  localparam int POS_W       = 2;
  localparam int OP_W        = 3;
  localparam int DATA_W      = 32;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_A    = 3'd0,
    OP_LOAD_B    = 3'd1,
    OP_LOAD_BASE = 3'd2,
    OP_ADD       = 3'd3,
    OP_SUB       = 3'd4,
    OP_MUL       = 3'd5,
    OP_SCALE     = 3'd6,
    OP_TRANSPOSE = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_EX,
    ST_ACC,
    ST_OUT
  } state_t;

endpackage

// ===== design/matrix3_integer_alu.sv =====
// matrix3_integer_alu: 3x3 signed integer matrix unit, A kept in one synchronous
// memory and B with base in a second, one element computed at a time
// depends on m3alu_pkg
//
// Usage: transactions enter on in_valid/in_ready with operation, row, col and
// value. Loads (A, B, base) write one element in the accepting cycle and give
// no result; a load with row or col out of range is dropped. Compute
// operations give nine results on out_valid/out_ready in row-major order,
// with last set on the final one.
// Steps per result element: add, subtract and transpose go through memory
// read, execute and output; scalar multiply adds a step for the registered
// product; the matrix product reads, multiplies and accumulates for each of
// three terms through the one multiplier, then outputs. in_ready is high
// only between compute items; the next item is taken while the last result
// still waits in the output register.
// A stalled receiver holds the output register and freezes the sequencer at
// its output step. Synchronous reset returns the sequencer to idle and
// empties the output register; matrix contents are undefined until loaded.

module matrix3_integer_alu
  import m3alu_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [OP_W-1:0]          operation,
  input  logic [POS_W-1:0]         row,
  input  logic [POS_W-1:0]         col,
  input  logic signed [DATA_W-1:0] value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [POS_W-1:0]         out_row,
  output logic [POS_W-1:0]         out_col,
  output logic signed [DATA_W-1:0] element,
  output logic                     last
);

  // B in the lower half, base in the upper half
  localparam int BB_W = $clog2(2 * CELLS);

  logic [DATA_W-1:0] mem_a      [CELLS];
  logic [DATA_W-1:0] mem_b_base [2 * CELLS];

  logic [DATA_W-1:0] a_q, b_q;
  logic [CELL_W-1:0] addr_a, addr_b, addr_base, addr_here, addr_wr;
  logic [BB_W-1:0]   addr_bb;

  state_t            state, state_next;
  op_t               op, in_op;
  logic [DATA_W-1:0] scalar;
  logic [IDX_W-1:0]  r, c, k;
  logic [DATA_W-1:0] prod, acc, res, sum;
  logic              in_fire, is_load, in_range, out_free;
  logic              k_last, c_last, r_last;

  assign in_op    = op_t'(operation);
  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign is_load  = (in_op == OP_LOAD_A) || (in_op == OP_LOAD_B) ||
                    (in_op == OP_LOAD_BASE);
  assign in_range = (32'(row) < MATRIX_SIZE) && (32'(col) < MATRIX_SIZE);
  assign addr_wr  = CELL_W'(32'(row) * MATRIX_SIZE + 32'(col));
  assign out_free = !out_valid || out_ready;

  assign k_last = (32'(k) == MATRIX_SIZE - 1);
  assign c_last = (32'(c) == MATRIX_SIZE - 1);
  assign r_last = (32'(r) == MATRIX_SIZE - 1);

  // read addresses follow the element counters
  assign addr_here = CELL_W'(32'(r) * MATRIX_SIZE + 32'(c));
  always_comb begin
    addr_a    = addr_here;
    addr_b    = addr_here;
    addr_base = addr_here;
    if (op == OP_MUL) begin
      addr_a = CELL_W'(32'(r) * MATRIX_SIZE + 32'(k));
      addr_b = CELL_W'(32'(k) * MATRIX_SIZE + 32'(c));
    end
    if (op == OP_TRANSPOSE) begin
      addr_base = CELL_W'(32'(c) * MATRIX_SIZE + 32'(r));
    end
    addr_bb = BB_W'(addr_b);
    if (op == OP_SCALE || op == OP_TRANSPOSE) begin
      addr_bb = BB_W'(32'(addr_base) + CELLS);
    end
  end

  // matrix memories: one write port, one registered read port each
  always_ff @(posedge clk) begin
    if (in_fire && in_range) begin
      case (in_op)
        OP_LOAD_A:    mem_a[addr_wr] <= value;
        OP_LOAD_B:    mem_b_base[BB_W'(addr_wr)] <= value;
        OP_LOAD_BASE: mem_b_base[BB_W'(32'(addr_wr) + CELLS)] <= value;
        default: ;
      endcase
    end
    a_q <= mem_a[addr_a];
    b_q <= mem_b_base[addr_bb];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire && !is_load) state_next = ST_RD;
      end
      ST_RD: state_next = ST_EX;
      ST_EX: begin
        if (op == OP_MUL || op == OP_SCALE) state_next = ST_ACC;
        else state_next = ST_OUT;
      end
      ST_ACC: begin
        if (op == OP_MUL && !k_last) state_next = ST_RD;
        else state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          if (r_last && c_last) state_next = ST_IDLE;
          else state_next = ST_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // first term of a dot product starts the sum from zero
  assign sum = ((k == '0) ? '0 : acc) + prod;

  always_ff @(posedge clk) begin
    if (in_fire && !is_load) begin
      op     <= in_op;
      scalar <= value;
      r      <= '0;
      c      <= '0;
      k      <= '0;
    end
    case (state)
      ST_EX: begin
        case (op)
          OP_ADD:   res  <= a_q + b_q;
          OP_SUB:   res  <= a_q - b_q;
          OP_MUL:   prod <= a_q * b_q;
          OP_SCALE: prod <= b_q * scalar;
          default:  res  <= b_q;
        endcase
      end
      ST_ACC: begin
        if (op == OP_MUL) begin
          acc <= sum;
          if (k_last) res <= sum;
          else k <= k + 1'b1;
        end else begin
          res <= prod;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          k <= '0;
          if (c_last) begin
            c <= '0;
            r <= r + 1'b1;
          end else begin
            c <= c + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      out_row <= POS_W'(r);
      out_col <= POS_W'(c);
      element <= res;
      last    <= r_last && c_last;
    end
  end

  a_compute_starts: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !is_load) |=> (state == ST_RD))
    else $error("compute transaction did not start a read");

  a_last_corner: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |->
      (32'(out_row) == MATRIX_SIZE - 1) && (32'(out_col) == MATRIX_SIZE - 1))
    else $error("last flag away from the final element");

  a_acc_ops: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ACC) |-> (op == OP_MUL || op == OP_SCALE))
    else $error("accumulate step for an operation without a product");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && !out_free) |=> (state == ST_OUT))
    else $error("sequencer left output step while receiver stalls");

endmodule
